// ===== rtl/core/nearest_length_request_queue_macros.svh =====
// Assertion macros, included by the top-level queue module.
`ifndef NEAREST_LENGTH_REQUEST_QUEUE_MACROS_SVH
`define NEAREST_LENGTH_REQUEST_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NLRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nlrq same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NLRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nlrq next-cycle check failed");

`endif

// ===== rtl/core/nlrq_pkg.sv =====
package nlrq_pkg;

  localparam int FIELD_W   = 20;
  localparam int IDEAL_W   = 24;
  localparam int CAP_W     = 32;
  localparam int WAIT_W    = 7;
  localparam int FRAC_BITS = 4;

  localparam logic ACT_ENQ  = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic shift_start;
    logic shift_rd;
    logic remove;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_last;
    logic pipe_busy;
    logic have;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/nlrq_ctrl.sv =====
module nlrq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  input  nlrq_pkg::sts_t sts,
  output logic          in_ready,
  output nlrq_pkg::cmd_t cmd
);
  import nlrq_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_action == ACT_PULL && !sts.empty) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait until the last compare has settled the best entry.
        if (!sts.pipe_busy) begin
          if (sts.have) begin
            cmd.shift_start = 1'b1;
            state_nxt       = ST_SHIFT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) begin
          cmd.remove = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          cmd.shift_rd = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/nlrq_dp.sv =====
module nlrq_dp #(
  parameter int DEPTH       = 64,
  parameter int LENGTH_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nlrq_pkg::cmd_t                      cmd,
  output nlrq_pkg::sts_t                      sts,
  input  logic                                in_action,
  input  logic [nlrq_pkg::FIELD_W-1:0]        in_prompt_length,
  input  logic [nlrq_pkg::FIELD_W-1:0]        in_decode_total,
  input  logic [nlrq_pkg::IDEAL_W-1:0]        in_ideal_length_q4,
  input  logic signed [nlrq_pkg::CAP_W-1:0]   in_capacity_room,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [nlrq_pkg::FIELD_W-1:0]        out_prompt_length,
  output logic [nlrq_pkg::FIELD_W-1:0]        out_decode_total,
  output logic [nlrq_pkg::WAIT_W-1:0]         out_waiting_count,
  output logic                                out_rejected
);
  import nlrq_pkg::*;

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 2 * LENGTH_BITS;
  localparam int SCL_W   = LENGTH_BITS + FRAC_BITS;
  localparam int DEV_W   = (SCL_W > IDEAL_W) ? SCL_W : IDEAL_W;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Entry store: prompt in the upper half, decode budget in the lower half.
  logic [ENTRY_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       ptr_r;
  logic                   action_r;
  logic                   rej_r;
  logic [IDEAL_W-1:0]     ideal_r;
  logic [CAP_W-1:0]       cap_r;

  // Read stage.
  logic [ENTRY_W-1:0]     rd_data_r;
  logic [CNT_W-1:0]       rd_idx_r;
  logic                   rd_vld_r;
  logic                   sh_vld_r;

  // Distance stage.
  logic                   cmp_vld_r;
  logic                   fit_r;
  logic [DEV_W-1:0]       dev_r;
  logic [AW-1:0]          cmp_idx_r;
  logic [ENTRY_W-1:0]     cmp_data_r;

  // Best so far.
  logic                   have_r;
  logic [DEV_W-1:0]       best_dev_r;
  logic [AW-1:0]          best_idx_r;
  logic [ENTRY_W-1:0]     best_data_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [FIELD_W-1:0]     out_prompt_r;
  logic [FIELD_W-1:0]     out_decode_r;
  logic [WAIT_W-1:0]      out_wait_r;
  logic                   out_rej_r;

  logic                   full;
  logic                   enq_wr;
  logic [LENGTH_BITS-1:0] rd_prompt;
  logic [DEV_W-1:0]       scaled;
  logic [DEV_W-1:0]       ideal_x;
  logic [DEV_W-1:0]       dev;
  logic                   fit;
  logic [CNT_W-1:0]       sh_waddr;
  logic                   better;
  logic                   res_found;

  assign full      = (count_r == CNT_FULL);
  assign enq_wr    = cmd.load && (in_action == ACT_ENQ) && !full;
  assign rd_prompt = rd_data_r[ENTRY_W-1:LENGTH_BITS];
  assign scaled    = DEV_W'({rd_prompt, {FRAC_BITS{1'b0}}});
  assign ideal_x   = DEV_W'(ideal_r);
  assign dev       = (scaled >= ideal_x) ? (scaled - ideal_x) : (ideal_x - scaled);
  // A negative limit admits nothing; otherwise an unsigned compare suffices.
  assign fit       = !cap_r[CAP_W-1] && (CAP_W'(rd_prompt) <= cap_r);
  assign sh_waddr  = rd_idx_r - CNT_ONE;
  // Strictly smaller distance only, so the oldest entry keeps a tie.
  assign better    = cmp_vld_r && fit_r && (!have_r || (dev_r < best_dev_r));
  assign res_found = (action_r == ACT_PULL) && have_r;

  always_comb begin
    sts.empty      = (count_r == '0);
    sts.scan_last  = ((ptr_r + CNT_ONE) == count_r);
    sts.pipe_busy  = rd_vld_r || cmp_vld_r;
    sts.have       = have_r;
    sts.shift_done = (ptr_r == count_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (enq_wr) begin
      mem[count_r[AW-1:0]] <= {LENGTH_BITS'(in_prompt_length),
                               LENGTH_BITS'(in_decode_total)};
    end else if (sh_vld_r) begin
      mem[sh_waddr[AW-1:0]] <= rd_data_r;
    end
    if (cmd.scan_rd || cmd.shift_rd) begin
      rd_data_r <= mem[ptr_r[AW-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r   <= ptr_r;
    fit_r      <= fit;
    dev_r      <= dev;
    cmp_idx_r  <= rd_idx_r[AW-1:0];
    cmp_data_r <= rd_data_r;
    if (cmd.load) begin
      action_r <= in_action;
      rej_r    <= (in_action == ACT_ENQ) && full;
      ideal_r  <= in_ideal_length_q4;
      cap_r    <= in_capacity_room;
    end
    if (better) begin
      best_dev_r  <= dev_r;
      best_idx_r  <= cmp_idx_r;
      best_data_r <= cmp_data_r;
    end
    if (cmd.finish) begin
      out_found_r  <= res_found;
      out_prompt_r <= res_found ? FIELD_W'(best_data_r[ENTRY_W-1:LENGTH_BITS]) : '0;
      out_decode_r <= res_found ? FIELD_W'(best_data_r[LENGTH_BITS-1:0]) : '0;
      out_wait_r   <= WAIT_W'(count_r);
      out_rej_r    <= (action_r == ACT_ENQ) && rej_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      sh_vld_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.scan_rd;
      sh_vld_r  <= cmd.shift_rd;
      cmp_vld_r <= rd_vld_r;
      if (enq_wr) begin
        count_r <= count_r + CNT_ONE;
      end else if (cmd.remove) begin
        count_r <= count_r - CNT_ONE;
      end
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.shift_start) begin
        ptr_r <= CNT_W'(best_idx_r) + CNT_ONE;
      end else if (cmd.scan_rd || cmd.shift_rd) begin
        ptr_r <= ptr_r + CNT_ONE;
      end
      if (cmd.load) begin
        have_r <= 1'b0;
      end else if (better) begin
        have_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_prompt_length = out_prompt_r;
  assign out_decode_total  = out_decode_r;
  assign out_waiting_count = out_wait_r;
  assign out_rejected      = out_rej_r;

endmodule

// ===== rtl/core/nearest_length_request_queue.sv =====
// Chan  Handshake            Beat fields
// in_   in_valid/in_ready    action, prompt_length, decode_total, ideal_length_q4, capacity_room
// out_  out_valid/out_ready  found, prompt_length, decode_total, waiting_count, rejected
//
// One beat is in work at a time. An enqueue, or a pull on an empty store, goes from IDLE
// straight to FINISH, and the controller is back in IDLE, ready for the next beat, when
// the result shows. A pull reads every entry, drains the read, distance and compare
// stages, moves the later entries down over the chosen one, and loads the result
// register; when nothing fits the move is skipped. Reset (rst_n low, synchronous) empties
// the store but leaves entry contents; a stalled result only holds the next beat at its
// final step until the output register frees up.

module nearest_length_request_queue #(
  parameter int DEPTH       = 64,
  parameter int LENGTH_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [nlrq_pkg::FIELD_W-1:0]       in_prompt_length,
  input  logic [nlrq_pkg::FIELD_W-1:0]       in_decode_total,
  input  logic [nlrq_pkg::IDEAL_W-1:0]       in_ideal_length_q4,
  input  logic signed [nlrq_pkg::CAP_W-1:0]  in_capacity_room,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [nlrq_pkg::FIELD_W-1:0]       out_prompt_length,
  output logic [nlrq_pkg::FIELD_W-1:0]       out_decode_total,
  output logic [nlrq_pkg::WAIT_W-1:0]        out_waiting_count,
  output logic                               out_rejected
);
  import nlrq_pkg::*;

  `include "nearest_length_request_queue_macros.svh"

  // The controller sequences accept, scan, drain, shift and finish; the
  // datapath owns the entry store, the distance pipeline and the result register.
  cmd_t cmd;
  sts_t sts;

  nlrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  nlrq_dp #(
    .DEPTH       (DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_prompt_length   (in_prompt_length),
    .in_decode_total    (in_decode_total),
    .in_ideal_length_q4 (in_ideal_length_q4),
    .in_capacity_room   (in_capacity_room),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_prompt_length  (out_prompt_length),
    .out_decode_total   (out_decode_total),
    .out_waiting_count  (out_waiting_count),
    .out_rejected       (out_rejected)
  );

  // A result never reports both a removed entry and a dropped enqueue.
  `NLRQ_ASSERT_IMP(a_found_rej_excl, clk, rst_n, out_valid, !(out_found && out_rejected))
  // The reported count never exceeds the store size.
  `NLRQ_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_waiting_count <= DEPTH)
  // Shifting only starts once a fitting entry has been chosen.
  `NLRQ_ASSERT_IMP(a_shift_has_best, clk, rst_n, cmd.shift_start, sts.have)
  // Finishing always presents a result on the next cycle.
  `NLRQ_ASSERT_NXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid)

endmodule

// ===== sim/nearest_length_request_queue_tb.sv =====
// Testbench for nearest_length_request_queue.
//
// Beats are queued up front by an initial block: a short directed list
// that walks the corner cases of the nearest-length search, then about
// 1700 random beats in segments that lean toward filling, holding or
// draining the store. A clocked driver sends them over the in_ channel.
// On every accepted beat it also runs the beat through a behavioral copy
// of the store and queues the reply that the block must give. A clocked
// monitor takes replies from the out_ channel and compares each field
// with the oldest queued reply.
module nearest_length_request_queue_tb;
  import nlrq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_BEATS = 1700;
  // Long enough for a pull over a full store to finish.
  localparam int DRAIN_CYCLES = 200;

  // One beat on the request side, at the block's widths.
  typedef struct {
    logic                     action;
    logic [FIELD_W-1:0]       prompt_length;
    logic [FIELD_W-1:0]       decode_total;
    logic [IDEAL_W-1:0]       ideal_q4;
    logic signed [CAP_W-1:0]  capacity;
  } request_t;

  // One beat on the reply side.
  typedef struct {
    logic                     found;
    logic [FIELD_W-1:0]       prompt_length;
    logic [FIELD_W-1:0]       decode_total;
    logic [WAIT_W-1:0]        waiting_count;
    logic                     rejected;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_action = ACT_ENQ;
  logic [FIELD_W-1:0]       in_prompt_length = '0;
  logic [FIELD_W-1:0]       in_decode_total = '0;
  logic [IDEAL_W-1:0]       in_ideal_length_q4 = '0;
  logic signed [CAP_W-1:0]  in_capacity_room = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_found;
  logic [FIELD_W-1:0]       out_prompt_length;
  logic [FIELD_W-1:0]       out_decode_total;
  logic [WAIT_W-1:0]        out_waiting_count;
  logic                     out_rejected;

  // Beats waiting to be sent, the beat on the bus, and replies still owed.
  request_t pending_beats[$];
  request_t beat_on_bus;
  reply_t   owed_replies[$];

  // Behavioral copy of the request store, kept in arrival order.
  logic [FIELD_W-1:0] held_prompt [QUEUE_DEPTH];
  logic [FIELD_W-1:0] held_decode [QUEUE_DEPTH];
  int                 held_count = 0;

  int accepted_beats = 0;
  int total_beats = 0;
  int error_count = 0;

  nearest_length_request_queue #(
    .DEPTH       (QUEUE_DEPTH),
    .LENGTH_BITS (FIELD_W)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_prompt_length   (in_prompt_length),
    .in_decode_total    (in_decode_total),
    .in_ideal_length_q4 (in_ideal_length_q4),
    .in_capacity_room   (in_capacity_room),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_prompt_length  (out_prompt_length),
    .out_decode_total   (out_decode_total),
    .out_waiting_count  (out_waiting_count),
    .out_rejected       (out_rejected)
  );

  always #6 clk = ~clk;

  // Applies one request to the behavioral store and returns the reply that
  // the block owes for it. An enqueue appends unless the store is full. A
  // pull looks at entries whose prompt length is within the capacity (a
  // signed compare, so a negative capacity admits nothing), measures the
  // distance of the prompt length times 16 from the ideal length, and takes
  // the closest; the strict compare lets the oldest entry win a tie. Later
  // entries then close the gap so the order is kept.
  function automatic reply_t serve_request(request_t req);
    reply_t             rsp;
    int                 pick;
    logic [IDEAL_W-1:0] scaled;
    logic [IDEAL_W-1:0] gap;
    logic [IDEAL_W-1:0] best_gap;
    rsp = '{default: '0};
    pick = -1;
    best_gap = '0;
    if (req.action == ACT_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        rsp.rejected = 1'b1;
      end else begin
        held_prompt[held_count] = req.prompt_length;
        held_decode[held_count] = req.decode_total;
        held_count++;
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (longint'(held_prompt[i]) > longint'(req.capacity)) continue;
        scaled = {held_prompt[i], {FRAC_BITS{1'b0}}};
        gap = (scaled >= req.ideal_q4) ? scaled - req.ideal_q4 : req.ideal_q4 - scaled;
        if (pick < 0 || gap < best_gap) begin
          pick = i;
          best_gap = gap;
        end
      end
      if (pick >= 0) begin
        rsp.found = 1'b1;
        rsp.prompt_length = held_prompt[pick];
        rsp.decode_total = held_decode[pick];
        for (int i = pick; i + 1 < held_count; i++) begin
          held_prompt[i] = held_prompt[i + 1];
          held_decode[i] = held_decode[i + 1];
        end
        held_count--;
      end
    end
    rsp.waiting_count = WAIT_W'(held_count);
    return rsp;
  endfunction

  function automatic request_t make_beat(logic act, logic [FIELD_W-1:0] prompt,
                                         logic [FIELD_W-1:0] decode,
                                         logic [IDEAL_W-1:0] ideal,
                                         logic signed [CAP_W-1:0] cap);
    request_t req;
    req.action = act;
    req.prompt_length = prompt;
    req.decode_total = decode;
    req.ideal_q4 = ideal;
    req.capacity = cap;
    return req;
  endfunction

  // Appends one beat at the tail of the send queue.
  task automatic add_beat(request_t req);
    pending_beats.insert(pending_beats.size(), req);
  endtask

  // Random beat of the given kind. Every field is filled either way so that
  // all input bits toggle; the block ignores the fields an action does not use.
  // Prompt lengths cluster in a small range often enough to make near misses
  // and ties common, and capacities hit the sign boundary and the exact range
  // of stored lengths.
  function automatic request_t random_request(logic act);
    request_t req;
    req.action = act;
    case ($urandom_range(9))
      0, 1, 2, 3: req.prompt_length = FIELD_W'($urandom_range(40));
      4:          req.prompt_length = $urandom_range(1) ? '1 : '0;
      default:    req.prompt_length = FIELD_W'($urandom);
    endcase
    req.decode_total = FIELD_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2: req.ideal_q4 = IDEAL_W'($urandom_range(700));
      3:       req.ideal_q4 = $urandom_range(1) ? '1 : '0;
      default: req.ideal_q4 = IDEAL_W'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1:    req.capacity = $signed(CAP_W'($urandom));
      2, 3:    req.capacity = CAP_W'($urandom_range(48));
      4:       req.capacity = 32'sh7FFF_FFFF;
      5: begin
        case ($urandom_range(3))
          0:       req.capacity = 32'sh8000_0000;
          1:       req.capacity = -32'sd1;
          2:       req.capacity = '0;
          default: req.capacity = 32'sh000F_FFFF;
        endcase
      end
      default: req.capacity = CAP_W'($urandom_range(32'h000F_FFFF));
    endcase
    return req;
  endfunction

  // Idle percentages for the three pressure phases: sender mostly busy while
  // the receiver stalls hard, then the reverse, then no idling at all.
  function automatic int send_idle_pct();
    if (accepted_beats < total_beats / 3) return 16;
    if (accepted_beats < 2 * total_beats / 3) return 79;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_beats < total_beats / 3) return 79;
    if (accepted_beats < 2 * total_beats / 3) return 16;
    return 0;
  endfunction

  // Driver. The valid and the payload only change once the beat on the bus
  // has been taken (or when nothing is on the bus), and each signal gets a
  // single nonblocking assignment per edge. An accepted beat is predicted
  // right away; the block cannot answer it within the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_replies.insert(owed_replies.size(), serve_request(beat_on_bus));
        accepted_beats++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          beat_on_bus = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_action <= beat_on_bus.action;
          in_prompt_length <= beat_on_bus.prompt_length;
          in_decode_total <= beat_on_bus.decode_total;
          in_ideal_length_q4 <= beat_on_bus.ideal_q4;
          in_capacity_room <= beat_on_bus.capacity;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Monitor. Every reply beat is matched against the oldest owed reply; a
  // reply that nothing owes is an error by itself.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $error("reply beat with no request waiting for it");
          error_count++;
        end else begin
          want = owed_replies.pop_front();
          compare_field("found", want.found, out_found);
          compare_field("prompt_length", want.prompt_length, out_prompt_length);
          compare_field("decode_total", want.decode_total, out_decode_total);
          compare_field("waiting_count", want.waiting_count, out_waiting_count);
          compare_field("rejected", want.rejected, out_rejected);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  initial begin
    int       fill_pct;
    int       run_len;
    request_t req;

    // Directed part. The store starts empty.
    // A pull on an empty store finds nothing.
    add_beat(make_beat(ACT_PULL, '0, '0, '0, 32'sh7FFF_FFFF));
    // Extremes of the stored fields, plus two equal lengths for a tie.
    add_beat(make_beat(ACT_ENQ, '0, '1, '1, -32'sd1));
    add_beat(make_beat(ACT_ENQ, '1, '0, '0, '0));
    add_beat(make_beat(ACT_ENQ, 20'd100, 20'd1, '0, '0));
    add_beat(make_beat(ACT_ENQ, 20'd100, 20'd2, '0, '0));
    add_beat(make_beat(ACT_ENQ, 20'd300, 20'd3, '0, '0));
    // Negative capacities admit nothing, even with entries waiting.
    add_beat(make_beat(ACT_PULL, '0, '0, 24'd1600, -32'sd1));
    add_beat(make_beat(ACT_PULL, '1, '1, 24'd1600, 32'sh8000_0000));
    // Zero capacity with the largest ideal length: only the empty prompt fits.
    add_beat(make_beat(ACT_PULL, '0, '0, '1, '0));
    // Exact hit on two equal lengths: the older one must leave first.
    add_beat(make_beat(ACT_PULL, '0, '0, 24'd1600, 32'sh7FFF_FFFF));
    // Equal distance above and below the ideal length: the older wins again.
    add_beat(make_beat(ACT_PULL, '0, '0, 24'd3200, 32'sh7FFF_FFFF));
    // Largest ideal length picks the largest prompt.
    add_beat(make_beat(ACT_PULL, '0, '0, '1, 32'sh7FFF_FFFF));
    // Capacity one below the only entry, then exactly at it.
    add_beat(make_beat(ACT_PULL, '0, '0, '0, 32'sd299));
    add_beat(make_beat(ACT_PULL, '0, '0, '0, 32'sd300));
    // Fractional ideal lengths: a tie halfway between 5 and 6, then a
    // fraction that leans toward 7.
    add_beat(make_beat(ACT_ENQ, 20'd5, 20'd50, '0, '0));
    add_beat(make_beat(ACT_ENQ, 20'd6, 20'd60, '0, '0));
    add_beat(make_beat(ACT_PULL, '0, '0, 24'h58, 32'sd100));
    add_beat(make_beat(ACT_ENQ, 20'd7, 20'd70, '0, '0));
    add_beat(make_beat(ACT_PULL, '0, '0, 24'h69, 32'sd100));
    add_beat(make_beat(ACT_PULL, '0, '0, '0, 32'sh7FFF_FFFF));
    add_beat(make_beat(ACT_PULL, '0, '0, '0, 32'sh7FFF_FFFF));

    // Random part. Open with a burst of enqueues that overfills the store so
    // rejections show up early, then alternate segments that lean toward
    // filling, holding steady, or draining.
    for (int i = 0; i < QUEUE_DEPTH + 8; i++) begin
      add_beat(random_request(ACT_ENQ));
    end
    while (pending_beats.size() < RANDOM_BEATS + 21) begin
      case ($urandom_range(2))
        0:       fill_pct = 85;
        1:       fill_pct = 50;
        default: fill_pct = 25;
      endcase
      run_len = $urandom_range(80, 20);
      for (int i = 0; i < run_len; i++) begin
        req = random_request(($urandom_range(99) < fill_pct) ? ACT_ENQ : ACT_PULL);
        add_beat(req);
      end
    end
    total_beats = pending_beats.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every beat is sent and every reply has come back, then give
    // the block a full pull's worth of cycles to show any stray reply.
    while (pending_beats.size() > 0 || in_valid || owed_replies.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, with every pull scanning
  // a full store and both sides stalling hard.
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== nearest_length_request_queue.f =====
+incdir+rtl/core
rtl/core/nlrq_pkg.sv
rtl/core/nlrq_ctrl.sv
rtl/core/nlrq_dp.sv
rtl/core/nearest_length_request_queue.sv
sim/nearest_length_request_queue_tb.sv
